[sv/fspa_pkg.sv]
// Shared types, constants and helper functions for the fan and strip primitive assembler.
`timescale 1ns / 1ps

package fspa_pkg;

    localparam int IndexWidth  = 32;
    localparam int CountWidth  = 24;
    localparam int LengthWidth = 16;
    localparam int CfgIdxWidth = 2;
    localparam int CfgDataWidth = 24;
    localparam int QueueDepth  = 4;
    localparam int QueuePtrWidth = $clog2(QueueDepth);
    localparam int QueueCntWidth = $clog2(QueueDepth + 1);

    localparam logic [CfgIdxWidth-1:0] CFG_ASSEMBLY_MODE    = 2'd0;
    localparam logic [CfgIdxWidth-1:0] CFG_SHORT_OUTPUT     = 2'd1;
    localparam logic [CfgIdxWidth-1:0] CFG_CAPACITY_INDICES = 2'd2;

    localparam logic MODE_FAN   = 1'b0;
    localparam logic MODE_STRIP = 1'b1;

    localparam logic [CountWidth-1:0] CAPACITY_RESET = {CountWidth{1'b1}};
    localparam logic [CountWidth-1:0] TRI_INDICES = 24'd3;

    typedef struct packed {
        logic [IndexWidth-1:0] vertex_a;
        logic [IndexWidth-1:0] vertex_b;
        logic [IndexWidth-1:0] vertex_c;
        logic [CountWidth-1:0] indices_total;
    } tri_t;

    // Indices a fan list of the given length needs: 3 * (length - 2) for lengths above 2.
    function automatic logic [CountWidth:0] fan_need(input logic [LengthWidth-1:0] len);
        logic [LengthWidth-1:0] d;
        logic [LengthWidth+1:0] n;
        d = len - 16'd2;
        n = {2'b00, d} + {1'b0, d, 1'b0};
        if (len > 16'd2)
        begin
            fan_need = {{(CountWidth-LengthWidth-1){1'b0}}, n};
        end
        else
        begin
            fan_need = '0;
        end
    endfunction

    function automatic logic [IndexWidth-1:0] shape_index(input logic short_out,
                                                          input logic [IndexWidth-1:0] v);
        if (short_out)
        begin
            shape_index = {16'h0000, v[15:0]};
        end
        else
        begin
            shape_index = v;
        end
    endfunction

endpackage

[sv/fspa_front.sv]
// Front part: configuration registers, list and strip state, and triangle formation per item.
`timescale 1ns / 1ps

module fspa_front
    import fspa_pkg::*;
(
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    cfg_write,
    input  logic [CfgIdxWidth-1:0]  cfg_index,
    input  logic [CfgDataWidth-1:0] cfg_data,
    input  logic                    accept,
    input  logic [IndexWidth-1:0]   index_value,
    input  logic                    first_in_list,
    input  logic [LengthWidth-1:0]  list_size,
    input  logic                    new_mesh,
    output logic                    push,
    output tri_t                    push_tri
);

    logic                   mode_reg;
    logic                   short_reg;
    logic [CountWidth-1:0]  cap_reg;

    logic [LengthWidth-1:0] list_position_reg, list_position_next;
    logic [LengthWidth-1:0] list_limit_reg, list_limit_next;
    logic [IndexWidth-1:0]  fan_center_reg, fan_center_next;
    logic [IndexWidth-1:0]  older_vertex_reg, older_vertex_next;
    logic [IndexWidth-1:0]  newer_vertex_reg, newer_vertex_next;
    logic                   older_valid_reg, older_valid_next;
    logic                   newer_valid_reg, newer_valid_next;
    logic                   winding_flip_reg, winding_flip_next;
    logic [CountWidth-1:0]  emitted_count_reg, emitted_count_next;
    logic                   halted_reg, halted_next;

    logic                   emit;
    logic [IndexWidth-1:0]  ta, tb, tc;
    logic                   room_fan, room_tri;
    logic [CountWidth-1:0]  base_count;

    assign base_count = new_mesh ? '0 : emitted_count_reg;
    assign room_fan = ({1'b0, base_count} + fan_need(list_size)) <= {1'b0, cap_reg};
    assign room_tri = ({1'b0, base_count} + {1'b0, TRI_INDICES}) <= {1'b0, cap_reg};

    always_comb
    begin
        list_position_next = list_position_reg;
        list_limit_next    = list_limit_reg;
        fan_center_next    = fan_center_reg;
        older_vertex_next  = older_vertex_reg;
        newer_vertex_next  = newer_vertex_reg;
        older_valid_next   = older_valid_reg;
        newer_valid_next   = newer_valid_reg;
        winding_flip_next  = winding_flip_reg;
        emitted_count_next = base_count;
        halted_next        = new_mesh ? 1'b0 : halted_reg;
        emit = 1'b0;
        ta = fan_center_reg;
        tb = newer_vertex_reg;
        tc = index_value;
        if (!halted_next)
        begin
            if (mode_reg == MODE_FAN)
            begin
                if (first_in_list)
                begin
                    list_limit_next    = list_size;
                    list_position_next = '0;
                    if (!room_fan)
                    begin
                        halted_next = 1'b1;
                    end
                end
                if (!halted_next && (list_position_next < list_limit_next))
                begin
                    list_position_next = list_position_next + 16'd1;
                    if (list_position_next == 16'd1)
                    begin
                        fan_center_next = index_value;
                    end
                    else if (list_position_next == 16'd2)
                    begin
                        newer_vertex_next = index_value;
                    end
                    else
                    begin
                        emit = 1'b1;
                        ta = fan_center_reg;
                        tb = newer_vertex_reg;
                        tc = index_value;
                        newer_vertex_next = index_value;
                    end
                end
            end
            else
            begin
                if (first_in_list)
                begin
                    if (!room_tri)
                    begin
                        halted_next = 1'b1;
                    end
                    else
                    begin
                        older_valid_next  = 1'b0;
                        newer_valid_next  = 1'b0;
                        winding_flip_next = 1'b1;
                    end
                end
                if (!halted_next)
                begin
                    if (index_value[IndexWidth-1])
                    begin
                        older_valid_next  = 1'b0;
                        newer_valid_next  = 1'b0;
                        winding_flip_next = 1'b1;
                    end
                    else if (!older_valid_next)
                    begin
                        older_vertex_next = index_value;
                        older_valid_next  = 1'b1;
                    end
                    else if (!newer_valid_next)
                    begin
                        newer_vertex_next = index_value;
                        newer_valid_next  = 1'b1;
                    end
                    else if (!room_tri)
                    begin
                        halted_next = 1'b1;
                    end
                    else
                    begin
                        emit = 1'b1;
                        winding_flip_next = !winding_flip_next;
                        older_vertex_next = newer_vertex_reg;
                        newer_vertex_next = index_value;
                        tc = index_value;
                        if (winding_flip_next)
                        begin
                            ta = newer_vertex_reg;
                            tb = older_vertex_reg;
                        end
                        else
                        begin
                            ta = older_vertex_reg;
                            tb = newer_vertex_reg;
                        end
                    end
                end
            end
        end
        if (emit)
        begin
            emitted_count_next = base_count + TRI_INDICES;
        end
    end

    assign push = accept && emit;
    assign push_tri.vertex_a      = shape_index(short_reg, ta);
    assign push_tri.vertex_b      = shape_index(short_reg, tb);
    assign push_tri.vertex_c      = shape_index(short_reg, tc);
    assign push_tri.indices_total = emitted_count_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg  <= MODE_FAN;
            short_reg <= 1'b0;
            cap_reg   <= CAPACITY_RESET;
        end
        else if (cfg_write)
        begin
            unique case (cfg_index)
                CFG_ASSEMBLY_MODE:    mode_reg  <= cfg_data[0];
                CFG_SHORT_OUTPUT:     short_reg <= cfg_data[0];
                CFG_CAPACITY_INDICES: cap_reg   <= cfg_data[CountWidth-1:0];
                default:              ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            list_position_reg <= '0;
            list_limit_reg    <= '0;
            fan_center_reg    <= '0;
            older_vertex_reg  <= '0;
            newer_vertex_reg  <= '0;
            older_valid_reg   <= 1'b0;
            newer_valid_reg   <= 1'b0;
            winding_flip_reg  <= 1'b1;
            emitted_count_reg <= '0;
            halted_reg        <= 1'b0;
        end
        else if (accept)
        begin
            list_position_reg <= list_position_next;
            list_limit_reg    <= list_limit_next;
            fan_center_reg    <= fan_center_next;
            older_vertex_reg  <= older_vertex_next;
            newer_vertex_reg  <= newer_vertex_next;
            older_valid_reg   <= older_valid_next;
            newer_valid_reg   <= newer_valid_next;
            winding_flip_reg  <= winding_flip_next;
            emitted_count_reg <= emitted_count_next;
            halted_reg        <= halted_next;
        end
    end

endmodule

[sv/fspa_queue.sv]
// Short triangle queue between the front part and the output stage.
`timescale 1ns / 1ps

module fspa_queue
    import fspa_pkg::*;
(
    input  logic clk,
    input  logic rst_n,
    input  logic push,
    input  tri_t push_tri,
    input  logic pop,
    output tri_t head_tri,
    output logic empty,
    output logic full
);

    tri_t                     mem [QueueDepth];
    logic [QueuePtrWidth-1:0] wr_ptr_reg;
    logic [QueuePtrWidth-1:0] rd_ptr_reg;
    logic [QueueCntWidth-1:0] count_reg;

    assign empty    = (count_reg == '0);
    assign full     = (count_reg == QueueCntWidth'(QueueDepth));
    assign head_tri = mem[rd_ptr_reg];

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem[wr_ptr_reg] <= push_tri;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (push)
            begin
                wr_ptr_reg <= wr_ptr_reg + 1'b1;
            end
            if (pop)
            begin
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            end
            if (push && !pop)
            begin
                count_reg <= count_reg + 1'b1;
            end
            else if (pop && !push)
            begin
                count_reg <= count_reg - 1'b1;
            end
        end
    end

endmodule

[sv/fspa_back.sv]
// Back part: output register that presents one triangle item at a time.
`timescale 1ns / 1ps

module fspa_back
    import fspa_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  q_empty,
    input  tri_t                  head_tri,
    output logic                  pop,
    input  logic                  out_stall,
    output logic                  out_valid,
    output logic [IndexWidth-1:0] vertex_a,
    output logic [IndexWidth-1:0] vertex_b,
    output logic [IndexWidth-1:0] vertex_c,
    output logic [CountWidth-1:0] indices_total
);

    logic out_valid_reg;
    tri_t out_tri_reg;

    assign pop = !q_empty && (!out_valid_reg || !out_stall);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (pop)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (!out_stall)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (pop)
        begin
            out_tri_reg <= head_tri;
        end
    end

    assign out_valid     = out_valid_reg;
    assign vertex_a      = out_tri_reg.vertex_a;
    assign vertex_b      = out_tri_reg.vertex_b;
    assign vertex_c      = out_tri_reg.vertex_c;
    assign indices_total = out_tri_reg.indices_total;

endmodule

[sv/fan_strip_primitive_assembler.sv]
// Top level of the fan and strip primitive assembler.
//
// The input channel (in_valid, in_stall) takes one vertex index item per clock while in_stall
// is low, with its list marker, list length and new-mesh flag. Each item yields zero or one
// triangle item on the output channel (out_valid, out_stall), carrying three
// indices and the running count of emitted indices.
// Items are classified and the assembly state is updated in the cycle of acceptance;
// triangles then pass through a four-entry queue into an output register.
// A triangle is written into the queue when its input item is accepted and is then loaded
// into the output register; the sustained rate is one item per clock while in_stall is
// low.
// When the receiver stalls, the output register holds its item and the queue
// fills; in_stall rises once the queue is full and falls as soon as an entry drains.
// Configuration writes (cfg_write, cfg_index, cfg_data) take effect at the next edge
// and must be made while the block is idle; the block itself does not enforce this.
// Reset clears the queue, the output valid, the assembly state and sets the
// configuration to fan mode, full-width indices and the largest capacity.
`timescale 1ns / 1ps

module fan_strip_primitive_assembler
    import fspa_pkg::*;
(
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    cfg_write,
    input  logic [CfgIdxWidth-1:0]  cfg_index,
    input  logic [CfgDataWidth-1:0] cfg_data,
    input  logic                    in_valid,
    output logic                    in_stall,
    input  logic [IndexWidth-1:0]   index_value,
    input  logic                    first_in_list,
    input  logic [LengthWidth-1:0]  list_size,
    input  logic                    new_mesh,
    output logic                    out_valid,
    input  logic                    out_stall,
    output logic [IndexWidth-1:0]   vertex_a,
    output logic [IndexWidth-1:0]   vertex_b,
    output logic [IndexWidth-1:0]   vertex_c,
    output logic [CountWidth-1:0]   indices_total
);

    logic accept;
    logic push;
    tri_t push_tri;
    logic pop;
    tri_t head_tri;
    logic q_empty;
    logic q_full;

    assign in_stall = q_full;
    assign accept   = in_valid && !q_full;

    fspa_front u_front
    (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_write     (cfg_write),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data),
        .accept        (accept),
        .index_value   (index_value),
        .first_in_list (first_in_list),
        .list_size     (list_size),
        .new_mesh      (new_mesh),
        .push          (push),
        .push_tri      (push_tri)
    );

    fspa_queue u_queue
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (push),
        .push_tri (push_tri),
        .pop      (pop),
        .head_tri (head_tri),
        .empty    (q_empty),
        .full     (q_full)
    );

    fspa_back u_back
    (
        .clk           (clk),
        .rst_n         (rst_n),
        .q_empty       (q_empty),
        .head_tri      (head_tri),
        .pop           (pop),
        .out_stall     (out_stall),
        .out_valid     (out_valid),
        .vertex_a      (vertex_a),
        .vertex_b      (vertex_b),
        .vertex_c      (vertex_c),
        .indices_total (indices_total)
    );

endmodule
